@@ sv/hps_pkg.sv @@
// Package for the histogram peak spread block: beat types, controller states,
// command and status structs. No dependencies.
package hps_pkg;

  localparam int LEVELS    = 256;
  localparam int LVL_W     = 8;
  localparam int COUNT_W   = 21;
  localparam int SPREAD_W  = 22;
  localparam int SQ_W      = 41;
  localparam int TERM_W    = 46;
  localparam int ACC_W     = 48;
  localparam int DEN_W     = 42;
  localparam int FRAC_W    = 16;
  localparam int SIDE_TERMS = 5;
  localparam int DIV_STEPS = 22;
  localparam logic [LVL_W-1:0] HIGH_EDGE = 8'd250;
  localparam logic [LVL_W-1:0] LOW_EDGE  = 8'd5;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } pix_in_t;

  typedef struct packed {
    logic [21:0] spread;
    logic [7:0]  peak_level;
    logic [20:0] peak_count;
    logic        empty_res;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_INC, ST_SCAN, ST_SCAN_END, ST_TRD, ST_TSQ,
    ST_TACC, ST_DEN, ST_DINIT, ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ADDR_PIX, ADDR_STEP, ADDR_UP, ADDR_LO
  } addr_src_t;

  typedef struct packed {
    addr_src_t  addr_src;
    logic [7:0] step;
    logic [2:0] d;
    logic       accept;
    logic       clr_we;
    logic       inc;
    logic       clr_total;
    logic       scan_rd;
    logic       sq_cp;
    logic       sq_ld;
    logic       acc_add;
    logic       acc_clr;
    logic       div_init;
    logic       div_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic last;
    logic empty;
    logic up_en;
    logic lo_en;
  } dp_status_t;

endpackage

@@ sv/hps_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module hps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/hps_ctrl.sv @@
// Controller state machine for the histogram peak spread block.
// Depends on hps_pkg.
module hps_ctrl import hps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctl_cmd_t   cmd,
  output logic       busy,
  output logic       result_valid
);

  state_t     state, state_next;
  logic [7:0] step, step_next;
  logic [3:0] t;
  logic       t_up, t_en;

  // term index: first the upper side, then the lower side
  assign t    = step[3:0];
  assign t_up = (t < 4'(SIDE_TERMS));
  assign t_en = t_up ? status.up_en : status.lo_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd          = '0;
    cmd.addr_src = ADDR_STEP;
    cmd.step     = step;
    cmd.d        = t_up ? 3'(t + 4'd1) : 3'(t - 4'd4);
    busy         = 1'b1;
    result_valid = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_we    = 1'b1;
        cmd.clr_total = 1'b1;
        cmd.acc_clr   = 1'b1;
        step_next     = step + 8'd1;
        if (step == 8'(LEVELS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy         = 1'b0;
        cmd.addr_src = ADDR_PIX;
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_INC;
        end
      end
      ST_INC: begin
        cmd.addr_src = ADDR_PIX;
        cmd.inc      = 1'b1;
        step_next    = '0;
        state_next   = status.last ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        step_next   = step + 8'd1;
        if (step == 8'(LEVELS - 1)) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        step_next  = '0;
        state_next = ST_TRD;
      end
      ST_TRD: begin
        cmd.addr_src = t_up ? ADDR_UP : ADDR_LO;
        if (status.empty) begin
          state_next = ST_DONE;
        end else if (t_en) begin
          state_next = ST_TSQ;
        end else if (t == 4'(2 * SIDE_TERMS - 1)) begin
          state_next = ST_DEN;
        end else begin
          step_next = step + 8'd1;
        end
      end
      ST_TSQ: begin
        cmd.sq_ld  = 1'b1;
        state_next = ST_TACC;
      end
      ST_TACC: begin
        cmd.acc_add = 1'b1;
        if (t == 4'(2 * SIDE_TERMS - 1)) begin
          state_next = ST_DEN;
        end else begin
          step_next  = step + 8'd1;
          state_next = ST_TRD;
        end
      end
      ST_DEN: begin
        cmd.sq_ld  = 1'b1;
        cmd.sq_cp  = 1'b1;
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 8'd1;
        if (step == 8'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        result_valid = 1'b1;
        step_next    = '0;
        state_next   = ST_CLEAR;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ sv/hps_dp.sv @@
// Datapath: histogram RAM, peak scan, square/accumulate and the divider.
// Depends on hps_pkg and hps_ram.
module hps_dp import hps_pkg::*; #(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic       clk,
  input  logic       rst,
  input  pix_in_t    item,
  input  ctl_cmd_t   cmd,
  output dp_status_t status,
  output res_t       result
);

  localparam int TOT_W = $clog2(MAX_PIXELS + 1);

  logic [TOT_W-1:0]    total;
  logic [LVL_W-1:0]    pix_q, peak, scan_idx, addr;
  logic                last_q, scan_take, k2;
  logic                ram_we;
  logic [COUNT_W-1:0]  wdata, rdata, cp, mul_a;
  logic [SQ_W-1:0]     sq;
  logic [TERM_W-1:0]   term;
  logic [4:0]          d2;
  logic [ACC_W-1:0]    acc;
  logic [DEN_W-1:0]    den, rem;
  logic [DEN_W:0]      remw;
  logic [SPREAD_W-1:0] sh, quot;
  logic                ge;

  // RAM address select
  always_comb begin
    unique case (cmd.addr_src)
      ADDR_PIX:  addr = cmd.accept ? item.pixel : pix_q;
      ADDR_STEP: addr = cmd.step;
      ADDR_UP:   addr = peak + {5'b0, cmd.d};
      ADDR_LO:   addr = peak - {5'b0, cmd.d};
      default:   addr = cmd.step;
    endcase
  end

  assign ram_we = cmd.clr_we || (cmd.inc && (total < TOT_W'(MAX_PIXELS)));
  assign wdata  = cmd.clr_we ? '0 : rdata + COUNT_W'(1);

  hps_ram #(.WIDTH(COUNT_W), .DEPTH(LEVELS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // pixel count and latched beat
  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      last_q    <= 1'b0;
      scan_take <= 1'b0;
    end else begin
      scan_take <= cmd.scan_rd;
      if (cmd.clr_total) begin
        total <= '0;
      end else if (ram_we && cmd.inc) begin
        total <= total + TOT_W'(1);
      end
      if (cmd.accept) begin
        last_q <= item.last;
      end
    end
  end

  // peak scan: lowest level wins on ties
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_q <= item.pixel;
    end
    scan_idx <= cmd.step;
    if (scan_take && (scan_idx == '0 || rdata > cp)) begin
      cp   <= rdata;
      peak <= scan_idx;
    end
  end

  // square, weight and accumulate
  assign mul_a = cmd.sq_cp ? cp : rdata;
  assign d2    = 5'({2'b0, cmd.d} * {2'b0, cmd.d});
  assign term  = sq * d2;
  assign k2    = (peak >= LOW_EDGE) && (peak <= HIGH_EDGE);

  always_ff @(posedge clk) begin
    if (cmd.sq_ld) begin
      sq <= SQ_W'({21'b0, mul_a} * {21'b0, mul_a});
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + {2'b0, term};
    end
  end

  // restoring divider, one quotient bit a cycle
  assign remw = {rem, sh[SPREAD_W-1]};
  assign ge   = (remw >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      quot <= '0;
    end else if (cmd.div_init) begin
      den  <= k2 ? {sq, 1'b0} : {1'b0, sq};
      rem  <= acc[ACC_W-1:6];
      sh   <= {acc[5:0], {FRAC_W{1'b0}}};
      quot <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? DEN_W'(remw - {1'b0, den}) : remw[DEN_W-1:0];
      sh   <= {sh[SPREAD_W-2:0], 1'b0};
      quot <= {quot[SPREAD_W-2:0], ge};
    end
  end

  assign status.last  = last_q;
  assign status.empty = (cp == '0);
  assign status.up_en = (peak < HIGH_EDGE);
  assign status.lo_en = (peak > LOW_EDGE);

  assign result.spread     = status.empty ? '0 : quot;
  assign result.peak_level = status.empty ? '0 : peak;
  assign result.peak_count = cp;
  assign result.empty_res  = status.empty;

endmodule

@@ sv/histogram_peak_spread.sv @@
// Histogram peak spread, top level: controller plus datapath.
// Depends on hps_pkg, hps_ctrl, hps_dp.
//
//   channel   handshake            payload
//   input     start / busy         item   (pix_in_t: pixel, last)
//   result    result_valid strobe  result (res_t: spread, peak_level, peak_count, empty_res)
//
// Each pixel is one histogram RAM read followed by one write of the count.
// After the last pixel: the peak scan, then up to ten side terms (read, square,
// accumulate on one multiplier), the denominator, the restoring divider,
// then the result strobe.
// A RAM clearing pass follows each result and each reset; busy is high
// throughout. Results are shown for one cycle and cannot be stalled.
module histogram_peak_spread import hps_pkg::*; #(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  pix_in_t item,
  output logic    busy,
  output logic    result_valid,
  output res_t    result
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  hps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  hps_dp #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

@@ sv/hps_checker.sv @@
// Port-level checker for histogram_peak_spread, with its bind.
// Depends on hps_pkg.
module hps_checker import hps_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    result_valid,
  input res_t    result
);

  // accepted beat makes the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted beat");

  // result strobe lasts one cycle
  assert property (@(posedge clk) disable iff (rst) result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

  // result comes only while busy
  assert property (@(posedge clk) disable iff (rst) result_valid |-> busy)
    else $error("result while idle");

  // empty window gives zero spread
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.empty_res) |-> (result.spread == '0))
    else $error("empty window with nonzero spread");

  // clearing pass after reset
  assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("not busy after reset");

endmodule

bind histogram_peak_spread hps_checker u_hps_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
